[rtl/bba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_ASRCH  = 12'b0000_0000_0010,
		S_AREM   = 12'b0000_0000_0100,
		S_ASPL   = 12'b0000_0000_1000,
		S_FCHK   = 12'b0000_0001_0000,
		S_FBUD   = 12'b0000_0010_0000,
		S_FMRG   = 12'b0000_0100_0000,
		S_FFIN   = 12'b0000_1000_0000,
		S_ISTART = 12'b0001_0000_0000,
		S_IB     = 12'b0010_0000_0000,
		S_IC     = 12'b0100_0000_0000,
		S_RES    = 12'b1000_0000_0000
	} state_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		state_t step;
		logic   accept;
	} bba_cmd_t;

	typedef struct packed {
		logic op_in;
		logic op_q;
		logic found;
		logic bad;
		logic k_lt_max;
		logic merge_ok;
		logic hv_k;
		logic split_more;
		logic out_free;
	} bba_stat_t;

endpackage
`default_nettype wire

[rtl/bba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/bba_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl import bba_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  bba_stat_t  stat,
	output bba_cmd_t   cmd
);

	state_t state_q, nxt;
	state_t ret;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.step   = state_q;
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	assign ret        = (stat.op_q == OP_FREE) ? S_RES : S_ASPL;

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) nxt = (stat.op_in == OP_FREE) ? S_FCHK : S_ASRCH;
			end
			S_ASRCH:  nxt = stat.found ? S_AREM : S_RES;
			S_AREM:   nxt = S_ASPL;
			S_ASPL:   nxt = stat.split_more ? S_ISTART : S_RES;
			S_FCHK:   nxt = stat.bad ? S_RES : S_FBUD;
			S_FBUD:   nxt = stat.k_lt_max ? S_FMRG : S_FFIN;
			S_FMRG:   nxt = stat.merge_ok ? S_FBUD : S_FFIN;
			S_FFIN:   nxt = S_ISTART;
			S_ISTART: nxt = stat.hv_k ? S_IB : ret;
			S_IB:     nxt = S_IC;
			S_IC:     nxt = ret;
			S_RES:    nxt = stat.out_free ? S_IDLE : S_RES;
			default:  nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

endmodule
`default_nettype wire

[rtl/bba_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module bba_dp import bba_pkg::*; #(
	parameter int ORDER_MAX = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	input  bba_cmd_t    cmd,
	output bba_stat_t   stat,
	input  wire [23:0]  s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata
);

	localparam int AW = ORDER_MAX;
	localparam int OW = $clog2(ORDER_MAX + 1);
	localparam int MW = OW + 1;
	localparam int CW = (ORDER_MAX + 1 > 12) ? ORDER_MAX + 1 : 12;
	localparam int DEPTH = 1 << ORDER_MAX;
	localparam logic [OW-1:0] KMAX = OW'(ORDER_MAX);

	logic          op_q;
	logic [CW-1:0] need_q;
	logic [AW-1:0] pa_q, ia_q, s_q, h_q, l_q;
	logic [OW-1:0] k_q;
	logic          inpool_q;
	logic [1:0]    res_st_q;
	logic [AW-1:0] heads_q [0:ORDER_MAX];
	logic [ORDER_MAX:0] hv_q;
	logic          w0_meta_q, w0_left_q, w0_right_q;
	logic          ovr_meta_q, ovr_left_q, ovr_right_q;

	logic [AW-1:0] raddr;
	logic          meta_we, left_we, right_we;
	logic [AW-1:0] meta_wa, left_wa, right_wa;
	logic [MW-1:0] meta_wd;
	logic [AW-1:0] left_wd, right_wd;
	logic [MW-1:0] meta_raw, meta_rd;
	logic [AW-1:0] left_raw, left_rd, right_raw, right_rd;

	logic          found;
	logic [OW-1:0] kf;
	logic [CW-1:0] half_sz;
	logic [AW-1:0] half_a, bud, rm_x, newp;
	logic          split_more, merge_ok, single, do_rm, st_ok;
	logic [OW-1:0] kclamp;
	logic [9:0]    in_addr;
	logic          out_free;

	assign in_addr = s_tdata[21:12];

	bba_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
		.raddr(raddr), .rdata(meta_raw)
	);
	bba_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_left (
		.clk(clk), .we(left_we), .waddr(left_wa), .wdata(left_wd),
		.raddr(raddr), .rdata(left_raw)
	);
	bba_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_right (
		.clk(clk), .we(right_we), .waddr(right_wa), .wdata(right_wd),
		.raddr(raddr), .rdata(right_raw)
	);

	// word 0 holds the top-order free block until first written
	assign meta_rd  = ovr_meta_q  ? {1'b0, KMAX} : meta_raw;
	assign left_rd  = ovr_left_q  ? '0 : left_raw;
	assign right_rd = ovr_right_q ? '0 : right_raw;

	// lowest adequate non-empty order
	always_comb begin
		found = 1'b0;
		kf    = '0;
		for (int i = ORDER_MAX; i >= 0; i--) begin
			if (hv_q[i] && ((CW'(1) << i) >= need_q)) begin
				found = 1'b1;
				kf    = OW'(i);
			end
		end
	end

	assign half_sz    = (CW'(1) << k_q) >> 1;
	assign half_a     = pa_q + AW'(half_sz);
	assign split_more = (k_q != '0) && (half_sz >= need_q);
	assign bud        = pa_q ^ (AW'(1) << k_q);
	assign merge_ok   = !meta_rd[OW] && (meta_rd[OW-1:0] == k_q);
	assign kclamp     = (meta_rd[OW-1:0] > KMAX) ? KMAX : meta_rd[OW-1:0];
	assign rm_x       = (cmd.step == S_AREM) ? pa_q : s_q;
	assign single     = (left_rd == rm_x) && (right_rd == rm_x);
	assign do_rm      = (cmd.step == S_AREM) || ((cmd.step == S_FMRG) && merge_ok);
	assign newp       = (s_q < pa_q) ? s_q : pa_q;
	assign out_free   = !m_tvalid || m_tready;
	assign st_ok      = (res_st_q == ST_OK);

	assign stat.op_in      = s_tdata[0];
	assign stat.op_q       = op_q;
	assign stat.found      = found;
	assign stat.bad        = !inpool_q || !meta_rd[OW];
	assign stat.k_lt_max   = (k_q < KMAX);
	assign stat.merge_ok   = merge_ok;
	assign stat.hv_k       = hv_q[k_q];
	assign stat.split_more = split_more;
	assign stat.out_free   = out_free;

	always_comb begin
		raddr = heads_q[k_q];
		unique case (cmd.step)
			S_IDLE:  raddr = AW'(in_addr);
			S_ASRCH: raddr = heads_q[kf];
			S_FBUD:  raddr = bud;
			default: raddr = heads_q[k_q];
		endcase
	end

	always_comb begin
		meta_we  = 1'b0; meta_wa  = pa_q; meta_wd  = {1'b0, k_q};
		left_we  = 1'b0; left_wa  = ia_q; left_wd  = ia_q;
		right_we = 1'b0; right_wa = ia_q; right_wd = ia_q;
		unique case (cmd.step)
			S_AREM, S_FMRG: begin
				if (do_rm && !single) begin
					right_we = 1'b1; right_wa = left_rd;  right_wd = right_rd;
					left_we  = 1'b1; left_wa  = right_rd; left_wd  = left_rd;
				end
				if (cmd.step == S_FMRG && merge_ok) begin
					meta_we = 1'b1; meta_wa = newp; meta_wd = {1'b0, k_q + OW'(1)};
				end
			end
			S_ASPL: begin
				meta_we = 1'b1;
				if (split_more) begin
					meta_wa = half_a; meta_wd = {1'b0, k_q - OW'(1)};
				end else begin
					meta_wa = pa_q; meta_wd = {1'b1, k_q};
				end
			end
			S_FCHK: begin
				if (!stat.bad) begin
					meta_we = 1'b1; meta_wd = {1'b0, meta_rd[OW-1:0]};
				end
			end
			S_FFIN: begin
				meta_we = 1'b1;
			end
			S_ISTART: begin
				if (!hv_q[k_q]) begin
					left_we  = 1'b1;
					right_we = 1'b1;
				end
			end
			S_IB: begin
				left_we  = 1'b1; left_wd  = left_rd;
				right_we = 1'b1; right_wd = h_q;
			end
			S_IC: begin
				left_we  = 1'b1; left_wa  = h_q;
				right_we = 1'b1; right_wa = l_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.step)
			S_IDLE: begin
				if (cmd.accept) begin
					op_q     <= s_tdata[0];
					need_q   <= CW'(s_tdata[11:1]) + CW'(1);
					pa_q     <= AW'(in_addr);
					inpool_q <= ((in_addr >> ORDER_MAX) == '0);
					res_st_q <= ST_OK;
				end
			end
			S_ASRCH: begin
				pa_q <= heads_q[kf];
				k_q  <= kf;
				if (!found) res_st_q <= ST_NOSPACE;
			end
			S_ASPL: begin
				if (split_more) begin
					ia_q <= half_a;
					k_q  <= k_q - OW'(1);
				end
			end
			S_FCHK: begin
				k_q <= kclamp;
				if (stat.bad) res_st_q <= ST_BADFREE;
			end
			S_FBUD: s_q <= bud;
			S_FMRG: begin
				if (merge_ok) begin
					pa_q <= newp;
					k_q  <= k_q + OW'(1);
				end
			end
			S_FFIN:   ia_q <= pa_q;
			S_ISTART: h_q  <= heads_q[k_q];
			S_IB:     l_q  <= left_rd;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q        <= (ORDER_MAX + 1)'(1) << ORDER_MAX;
			for (int i = 0; i <= ORDER_MAX; i++) heads_q[i] <= '0;
			w0_meta_q   <= 1'b0;
			w0_left_q   <= 1'b0;
			w0_right_q  <= 1'b0;
			ovr_meta_q  <= 1'b0;
			ovr_left_q  <= 1'b0;
			ovr_right_q <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
		end else begin
			ovr_meta_q  <= (raddr == '0) && !w0_meta_q;
			ovr_left_q  <= (raddr == '0) && !w0_left_q;
			ovr_right_q <= (raddr == '0) && !w0_right_q;
			if (meta_we && meta_wa == '0)   w0_meta_q  <= 1'b1;
			if (left_we && left_wa == '0)   w0_left_q  <= 1'b1;
			if (right_we && right_wa == '0) w0_right_q <= 1'b1;

			if (do_rm) begin
				if (single) begin
					hv_q[k_q]    <= 1'b0;
					heads_q[k_q] <= '0;
				end else if (heads_q[k_q] == rm_x) begin
					heads_q[k_q] <= right_rd;
				end
			end
			if ((cmd.step == S_ISTART && !hv_q[k_q]) || cmd.step == S_IC) begin
				hv_q[k_q]    <= 1'b1;
				heads_q[k_q] <= ia_q;
			end

			if (cmd.step == S_RES && out_free) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {st_ok ? 4'(k_q) : 4'd0, st_ok ? 10'(pa_q) : 10'd0, res_st_q};
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/buddy_block_allocator_top.sv]
// One transaction at a time: a new request is accepted only in idle, once the
//   result has entered the output register; each takes as long as the header walk
//   through the registered-read memories, plus output stalls.
// Reset: asynchronous, active low; the pool comes up as one free block at
//   word 0 of top order, header memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_top import bba_pkg::*; #(
	parameter int ORDER_MAX = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [23:0]  s_tdata,  // operation, request_words, block_address, pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata   // status, result_address, result_order
);

	bba_cmd_t  cmd;
	bba_stat_t stat;

	bba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	bba_dp #(.ORDER_MAX(ORDER_MAX)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import bba_pkg::*;

	localparam int ORD_TOP = 10;
	localparam int POOL = 1 << ORD_TOP;

	typedef struct {
		logic [1:0] status;
		logic [9:0] addr;
		logic [3:0] order;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	buddy_block_allocator_top #(.ORDER_MAX(ORD_TOP)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// shadow of the allocator state
	bit         blk_tag[POOL];
	bit         blk_seen[POOL];
	logic [3:0] blk_ord[POOL];
	logic [9:0] blk_lnk_l[POOL];
	logic [9:0] blk_lnk_r[POOL];
	bit         head_ok[ORD_TOP+1];
	logic [9:0] head_addr[ORD_TOP+1];

	alloc_result_t pending_results[$];
	int            live_blocks[$];
	int            seen_addrs[$];
	int            mismatches = 0;
	bit            failed = 1'b0;
	bit            tx_gaps = 1'b1;
	bit            rx_gaps = 1'b1;
	int            hold_req = 0;
	int            hold_ack = 0;
	int            hold_left = 0;
	int            rx_wait = 0;

	function automatic void touch(int a);
		if (!blk_seen[a]) begin
			blk_seen[a] = 1'b1;
			seen_addrs.push_back(a);
		end
	endfunction

	function automatic void unlink(int a, int k);
		int l, r;
		l = blk_lnk_l[a];
		r = blk_lnk_r[a];
		if (l == a && r == a) begin
			head_ok[k] = 1'b0;
			head_addr[k] = '0;
		end else begin
			blk_lnk_r[l] = r[9:0];
			blk_lnk_l[r] = l[9:0];
			if (head_addr[k] == a)
				head_addr[k] = r[9:0];
		end
	endfunction

	function automatic void link_head(int a, int k);
		int h, l;
		touch(a);
		if (!head_ok[k]) begin
			blk_lnk_l[a] = a[9:0];
			blk_lnk_r[a] = a[9:0];
		end else begin
			h = head_addr[k];
			l = blk_lnk_l[h];
			blk_lnk_r[a] = h[9:0];
			blk_lnk_l[a] = l[9:0];
			blk_lnk_l[h] = a[9:0];
			blk_lnk_r[l] = a[9:0];
		end
		head_ok[k] = 1'b1;
		head_addr[k] = a[9:0];
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < POOL; i++) begin
			blk_tag[i] = 0; blk_seen[i] = 0; blk_ord[i] = 0;
			blk_lnk_l[i] = 0; blk_lnk_r[i] = 0;
		end
		for (int k = 0; k <= ORD_TOP; k++) begin
			head_ok[k] = 0; head_addr[k] = 0;
		end
		seen_addrs.delete();
		blk_ord[0] = ORD_TOP;
		touch(0);
		head_ok[ORD_TOP] = 1'b1;
	endfunction

	function automatic alloc_result_t predict_alloc(logic [10:0] words);
		alloc_result_t res;
		int need, k, pa, half;
		need = int'(words) + 1;
		k = 0;
		while (k <= ORD_TOP && !((1 << k) >= need && head_ok[k]))
			k++;
		if (k > ORD_TOP) begin
			res.status = ST_NOSPACE; res.addr = '0; res.order = '0;
			return res;
		end
		pa = head_addr[k];
		unlink(pa, k);
		while (k > 0 && (1 << (k - 1)) >= need) begin
			half = pa + (1 << (k - 1));
			k--;
			blk_tag[half] = 1'b0;
			blk_ord[half] = k[3:0];
			link_head(half, k);
		end
		blk_tag[pa] = 1'b1;
		blk_ord[pa] = k[3:0];
		res.status = ST_OK; res.addr = pa[9:0]; res.order = k[3:0];
		return res;
	endfunction

	function automatic alloc_result_t predict_free(logic [9:0] addr);
		alloc_result_t res;
		int p, k, bud;
		p = addr;
		if (!blk_tag[p]) begin
			res.status = ST_BADFREE; res.addr = '0; res.order = '0;
			return res;
		end
		k = blk_ord[p];
		if (k > ORD_TOP)
			k = ORD_TOP;
		blk_tag[p] = 1'b0;
		while (k < ORD_TOP) begin
			bud = p ^ (1 << k);
			if (blk_tag[bud] || blk_ord[bud] != k)
				break;
			unlink(bud, k);
			if (bud < p)
				p = bud;
			k++;
			blk_ord[p] = k[3:0];
		end
		blk_tag[p] = 1'b0;
		blk_ord[p] = k[3:0];
		link_head(p, k);
		res.status = ST_OK; res.addr = p[9:0]; res.order = k[3:0];
		return res;
	endfunction

	// one transaction on the input side, prediction at acceptance
	task automatic send_item(logic op, logic [10:0] words, logic [9:0] addr);
		alloc_result_t res;
		@(posedge clk);
		if (tx_gaps)
			repeat ($urandom_range(0, 16)) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, addr, words, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		s_tvalid <= 1'b0;
		if (op == OP_ALLOC)
			res = predict_alloc(words);
		else
			res = predict_free(addr);
		pending_results.push_back(res);
		if (res.status == ST_OK) begin
			if (op == OP_ALLOC)
				live_blocks.push_back(res.addr);
			else
				foreach (live_blocks[i])
					if (live_blocks[i] == addr) begin
						live_blocks.delete(i);
						break;
					end
		end
	endtask

	task automatic alloc_words(int n);
		send_item(OP_ALLOC, n[10:0], '0);
	endtask

	task automatic free_addr(int a);
		send_item(OP_FREE, '0, a[9:0]);
	endtask

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid && m_tready && rx_gaps)
				rx_wait <= $urandom_range(0, 16);
		end
	end

	always @(posedge clk) begin
		alloc_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				failed = 1'b1;
				if (mismatches < 10)
					$display("unexpected result %h", m_tdata);
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata[1:0] !== exp_res.status || m_tdata[11:2] !== exp_res.addr ||
						m_tdata[15:12] !== exp_res.order) begin
					failed = 1'b1;
					if (mismatches < 10)
						$display("mismatch: exp status %0d addr %0d order %0d, got %0d %0d %0d",
							exp_res.status, exp_res.addr, exp_res.order,
							m_tdata[1:0], m_tdata[11:2], m_tdata[15:12]);
					mismatches++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		alloc_words(0);        // smallest block, splits all the way down
		alloc_words(0);
		alloc_words(1);
		alloc_words(2047);     // larger than the pool
		alloc_words(1023);     // no top block left
		free_addr(0);
		free_addr(0);          // double free
		free_addr(1);
		free_addr(2);          // merges back to the whole pool
		alloc_words(1023);     // whole pool
		alloc_words(0);        // pool full
		free_addr(0);
		alloc_words(511);      // exactly half
		alloc_words(510);
		alloc_words(255);      // no space left
		free_addr(512);
		alloc_words(255);      // splits the freed half
		free_addr(768);        // bad free of a free quarter
		alloc_words(0);
		alloc_words(0);
		free_addr(768);        // its buddy is still allocated
		free_addr(512);        // buddy free but of lower order, no merge
		wait_drained();
		while (live_blocks.size() != 0)
			free_addr(live_blocks[0]);
	endtask

	task automatic random_item();
		int r, idx;
		r = $urandom_range(0, 99);
		if (live_blocks.size() == 0 || r < 52) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				alloc_words($urandom_range(0, 40));
			else if (r < 95)
				alloc_words($urandom_range(0, 1023));
			else
				alloc_words($urandom_range(0, 2047));
		end else if (r < 94) begin
			idx = $urandom_range(0, live_blocks.size() - 1);
			free_addr(live_blocks[idx]);
		end else begin
			idx = $urandom_range(0, seen_addrs.size() - 1);
			free_addr(seen_addrs[idx]);   // mostly a bad free
		end
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				tx_gaps = $urandom_range(0, 3) != 0;
				rx_gaps = $urandom_range(0, 3) != 0;
			end
			random_item();
		end
	endtask

	task automatic test_backpressure();
		hold_req++;
		tx_gaps = 1'b0;
		for (int i = 0; i < 30; i++)
			random_item();
		tx_gaps = 1'b1;
	endtask

	task automatic test_pause();
		wait_drained();
		for (int i = 0; i < 20; i++) begin
			random_item();
			wait_drained();
		end
	endtask

	initial begin
		pool_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400);
		test_backpressure();
		test_pause();
		test_random(400);
		test_backpressure();
		wait_drained();
		repeat (60) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("testbench failed");
		$finish;
	end

endmodule
